@@ rtl/ils_pkg.sv @@
//------------------------------------------------------------------------------
// ils_pkg: shared types and constants for the indexed list store
// Operation and status codes, transaction structs and the cell command struct.
//------------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int DATA_W       = 32;
	localparam int POS_W        = 8;
	localparam int OP_W         = 3;
	localparam int STATUS_W     = 2;
	localparam int LEN_W        = 5;

	typedef enum logic [OP_W-1:0] {
		OP_READ      = 3'd0,
		OP_INS_FRONT = 3'd1,
		OP_APPEND    = 3'd2,
		OP_INS_AT    = 3'd3,
		OP_DELETE    = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [STATUS_W-1:0]      status;
		logic [LEN_W-1:0]         length;
	} out_item_t;

	typedef struct packed {
		logic              ins;
		logic              del;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] value;
	} cell_cmd_t;

endpackage

`default_nettype wire

@@ rtl/ils_cell.sv @@
//------------------------------------------------------------------------------
// ils_cell: one storage cell of the list row
// Holds one entry; shifts from the left neighbor on insert, from the right
// neighbor on delete, and drives its entry onto the read tap when addressed.
//------------------------------------------------------------------------------
`default_nettype none

module ils_cell
	import ils_pkg::*;
#(
	parameter int IDX = 0
) (
	input  wire logic              clk,
	input  wire cell_cmd_t         cmd,
	input  wire logic [DATA_W-1:0] left_data,
	input  wire logic [DATA_W-1:0] right_data,
	output logic      [DATA_W-1:0] data,
	output logic      [DATA_W-1:0] tap
);

	localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

	logic [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		priority if (cmd.ins) begin
			if (MY_IDX == cmd.pos) begin
				data_q <= cmd.value;
			end else if (MY_IDX > cmd.pos) begin
				data_q <= left_data;
			end
		end else if (cmd.del && (MY_IDX >= cmd.pos)) begin
			data_q <= right_data;
		end else begin
			data_q <= data_q;
		end
	end

	assign data = data_q;
	assign tap  = (MY_IDX == cmd.pos) ? data_q : '0;

endmodule

`default_nettype wire

@@ rtl/indexed_list_store.sv @@
//------------------------------------------------------------------------------
// indexed_list_store: ordered list of signed 32-bit values
// Read, insert front, append, insert before position and delete position on
// a row of storage cells that all shift in the same clock.
//------------------------------------------------------------------------------
// The block takes one transaction per clock: busy stays low, and each
// transaction accepted on start gives exactly one result on rsp, marked by
// done, in the following cycle. done is a one-cycle strobe and the receiver
// cannot hold results off, so rsp must be taken in the cycle that done is high.
// Every insert or delete moves all later entries one cell in the same clock
// along the cell row; a read selects the addressed cell through an OR of the
// cell taps. The list is empty after reset and needs no clearing pass.
`default_nettype none

module indexed_list_store
	import ils_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire in_item_t req,
	output logic          done,
	output out_item_t     rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic [CNT_W-1:0]                count_q;
	logic [CNT_W-1:0]                count_next;
	logic                            done_q;
	out_item_t                       rsp_q;
	logic                            accept;
	logic                            full;
	logic [CMP_W-1:0]                pos_x;
	logic [CMP_W-1:0]                cnt_x;
	logic                            do_ins;
	logic                            do_del;
	logic [POS_W-1:0]                ins_pos;
	logic [DATA_W-1:0]               rd_value;
	status_t                         st;
	logic [DATA_W-1:0]               tap_or;
	cell_cmd_t                       cmd;
	logic [CAPACITY-1:0][DATA_W-1:0] cell_data;
	logic [CAPACITY-1:0][DATA_W-1:0] cell_tap;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign pos_x  = CMP_W'(req.position);
	assign cnt_x  = CMP_W'(count_q);

	always_comb begin
		rd_value = '1;
		st       = ST_DONE;
		do_ins   = 1'b0;
		do_del   = 1'b0;
		ins_pos  = req.position;
		unique case (req.op)
			OP_READ: begin
				if (pos_x < cnt_x) begin
					rd_value = tap_or;
				end else begin
					st = ST_RANGE;
				end
			end
			OP_INS_FRONT: begin
				ins_pos = '0;
				if (full) begin
					st = ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			OP_APPEND: begin
				ins_pos = POS_W'(count_q);
				if (full) begin
					st = ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			OP_INS_AT: begin
				if (pos_x > cnt_x) begin
					st = ST_RANGE;
				end else if (full) begin
					st = ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			OP_DELETE: begin
				if (pos_x >= cnt_x) begin
					st = ST_RANGE;
				end else begin
					do_del = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		cmd.ins   = accept && do_ins;
		cmd.del   = accept && do_del;
		cmd.pos   = ins_pos;
		cmd.value = req.value;
	end

	always_comb begin
		count_next = count_q;
		if (cmd.ins) begin
			count_next = count_q + CNT_W'(1);
		end else if (cmd.del) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_in;
		logic [DATA_W-1:0] right_in;

		if (i == 0) begin : g_first
			assign left_in = req.value;
		end else begin : g_mid_l
			assign left_in = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_in = cell_data[i];
		end else begin : g_mid_r
			assign right_in = cell_data[i+1];
		end

		ils_cell #(
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.left_data  (left_in),
			.right_data (right_in),
			.data       (cell_data[i]),
			.tap        (cell_tap[i])
		);
	end

	always_comb begin
		tap_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			tap_or = tap_or | cell_tap[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_next;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.read_value <= rd_value;
			rsp_q.status     <= st;
			rsp_q.length     <= LEN_W'(count_next);
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start))
		else $error("result without an accepted transaction");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_length_matches: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.length == LEN_W'(count_q)))
		else $error("reported length differs from entry count");

	a_full_holds_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == ST_FULL)) |-> $stable(count_q))
		else $error("dropped insert changed the entry count");

	a_nonread_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(req.op) != OP_READ)) |-> (rsp.read_value == '1))
		else $error("non-read transaction returned a value");

endmodule

`default_nettype wire

@@ dv/tb_indexed_list_store.sv @@
//------------------------------------------------------------------------------
// tb_indexed_list_store: self-checking testbench for the indexed list store
// Drives read, insert, append, positional insert, delete and spare op codes
// with random gaps, predicts each result with a behavioral list and compares
// every response field against it in order of issue.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_indexed_list_store
	import ils_pkg::*;
;

	localparam int CAP         = CAPACITY_DEF;
	localparam int NUM_RANDOM  = 400;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 8;

	localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

	localparam int MODE_GROW   = 0;
	localparam int MODE_SHRINK = 1;
	localparam int MODE_MIXED  = 2;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  req;
	logic      done;
	out_item_t rsp;

	in_item_t  pending_items[$];
	out_item_t expected_rsp[$];

	logic signed [DATA_W-1:0] list_vals [CAP];
	int list_len;
	int gen_len;
	int idle_left;
	int cycles;
	int accepted;
	int checked;
	int mismatches;
	int read_hits;
	int range_hits;
	int full_hits;
	int peak_len;

	indexed_list_store #(.CAPACITY(CAP)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void place_entry(int p, logic signed [DATA_W-1:0] v);
		for (int i = list_len; i > p; i--)
			list_vals[i] = list_vals[i-1];
		list_vals[p] = v;
		list_len++;
		if (list_len > peak_len)
			peak_len = list_len;
	endfunction

	function automatic void remove_entry(int p);
		for (int i = p; i + 1 < list_len; i++)
			list_vals[i] = list_vals[i+1];
		list_len--;
	endfunction

	function automatic out_item_t apply_list_op(in_item_t it);
		out_item_t r;
		int p;
		p = it.position;
		r.read_value = -1;
		r.status = ST_DONE;
		case (it.op)
			OP_READ: begin
				if (p < list_len) begin
					r.read_value = list_vals[p];
					read_hits++;
				end else
					r.status = ST_RANGE;
			end
			OP_INS_FRONT: begin
				if (list_len >= CAP)
					r.status = ST_FULL;
				else
					place_entry(0, it.value);
			end
			OP_APPEND: begin
				if (list_len >= CAP)
					r.status = ST_FULL;
				else
					place_entry(list_len, it.value);
			end
			OP_INS_AT: begin
				if (p > list_len)
					r.status = ST_RANGE;
				else if (list_len >= CAP)
					r.status = ST_FULL;
				else
					place_entry(p, it.value);
			end
			OP_DELETE: begin
				if (p >= list_len)
					r.status = ST_RANGE;
				else
					remove_entry(p);
			end
			default: ;
		endcase
		if (r.status == ST_RANGE)
			range_hits++;
		if (r.status == ST_FULL)
			full_hits++;
		r.length = LEN_W'(list_len);
		return r;
	endfunction

	// track the length the stimulus will leave behind, to aim positions
	function automatic int next_length(logic [OP_W-1:0] op, int pos, int len);
		case (op)
			OP_INS_FRONT, OP_APPEND: return (len < CAP) ? len + 1 : len;
			OP_INS_AT:               return (pos <= len && len < CAP) ? len + 1 : len;
			OP_DELETE:               return (pos < len) ? len - 1 : len;
			default:                 return len;
		endcase
	endfunction

	task automatic add_item(logic [OP_W-1:0] op, int pos, logic [DATA_W-1:0] val);
		in_item_t it;
		it.op = op;
		it.position = POS_W'(pos);
		it.value = val;
		pending_items.push_back(it);
		gen_len = next_length(op, pos, gen_len);
	endtask

	function automatic int pick_pos(int len);
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(0, len);
		else if (r < 95)
			return $urandom_range(0, CAP + 2);
		return $urandom_range(0, 255);
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 32'h8000_0000;
		if (r == 1)
			return 32'h7FFF_FFFF;
		if (r == 2)
			return 32'hFFFF_FFFF;
		if (r == 3)
			return '0;
		return $urandom;
	endfunction

	function automatic logic [OP_W-1:0] pick_op(int mode);
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return OP_W'($urandom_range(OP_SPARE5, OP_SPARE7));
		case (mode)
			MODE_GROW: begin
				if (r < 30) return OP_INS_FRONT;
				if (r < 50) return OP_APPEND;
				if (r < 75) return OP_INS_AT;
				if (r < 92) return OP_READ;
				return OP_DELETE;
			end
			MODE_SHRINK: begin
				if (r < 65) return OP_DELETE;
				if (r < 85) return OP_READ;
				return OP_APPEND;
			end
			default: return OP_W'($urandom_range(OP_READ, OP_DELETE));
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	always @(posedge clk) begin : driver
		in_item_t nxt_req;
		logic nxt_start;
		nxt_req = req;
		nxt_start = start;
		if (start && !busy) begin
			expected_rsp.push_back(apply_list_op(req));
			accepted++;
			nxt_start = 1'b0;
		end
		if (arst_n && !nxt_start) begin
			if (idle_left > 0)
				idle_left--;
			else if (pending_items.size() > 0) begin
				nxt_req = pending_items.pop_front();
				nxt_start = 1'b1;
				idle_left = pick_gap();
			end
		end
		start <= nxt_start;
		req <= nxt_req;
	end

	always @(posedge clk) begin : monitor
		out_item_t exp_item;
		if (arst_n && done) begin
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected response rd=%0d st=%0d len=%0d",
						$realtime, rsp.read_value, rsp.status, rsp.length);
			end else begin
				exp_item = expected_rsp.pop_front();
				checked++;
				if (rsp.read_value !== exp_item.read_value || rsp.status !== exp_item.status ||
						rsp.length !== exp_item.length) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch exp rd=%0d st=%0d len=%0d got rd=%0d st=%0d len=%0d",
							$realtime, exp_item.read_value, exp_item.status, exp_item.length,
							rsp.read_value, rsp.status, rsp.length);
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("indexed_list_store regression: fail");
			$finish;
		end
	end

	initial begin : stimulus
		int mode;
		int run;
		int n;
		logic [OP_W-1:0] op;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		list_len = 0;
		gen_len = 0;
		idle_left = 0;
		cycles = 0;
		accepted = 0;
		checked = 0;
		mismatches = 0;
		read_hits = 0;
		range_hits = 0;
		full_hits = 0;
		peak_len = 0;

		// empty list: every read or delete position and every insert past the end is out of range
		add_item(OP_READ, 0, '0);
		add_item(OP_READ, 255, '0);
		add_item(OP_DELETE, 0, '0);
		add_item(OP_INS_AT, 1, 32'h1234_5678);
		add_item(OP_SPARE5, 0, 32'hFFFF_FFFF);
		add_item(OP_SPARE6, 255, '0);
		add_item(OP_SPARE7, 3, 32'h8000_0000);
		add_item(OP_INS_AT, 0, 32'h8000_0000);
		add_item(OP_APPEND, 0, 32'h7FFF_FFFF);
		add_item(OP_INS_FRONT, 255, 32'hFFFF_FFFF);
		add_item(OP_INS_AT, 3, 32'h5A5A_5A5A);
		add_item(OP_INS_AT, 1, '0);
		for (int i = 0; i < 6; i++)
			add_item(OP_READ, i, '0);
		add_item(OP_INS_AT, 6, 32'hA5A5_A5A5);
		add_item(OP_INS_AT, 255, 32'h0000_0001);
		add_item(OP_DELETE, 255, '0);
		add_item(OP_DELETE, 4, '0);
		add_item(OP_DELETE, 0, '0);
		add_item(OP_READ, 0, '0);

		// first episode favours inserts to grow the list
		n = 0;
		mode = MODE_GROW;
		run = 30;
		while (n < NUM_RANDOM) begin
			for (int k = 0; k < run && n < NUM_RANDOM; k++) begin
				op = pick_op(mode);
				add_item(op, pick_pos(gen_len), pick_value());
				n++;
			end
			mode = $urandom_range(MODE_GROW, MODE_MIXED);
			run = $urandom_range(8, 40);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() > 0 || start || expected_rsp.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (expected_rsp.size() > 0) begin
			mismatches += expected_rsp.size();
			$display("%0d responses never arrived", expected_rsp.size());
		end
		$display("issued %0d transactions, checked %0d responses, %0d mismatches",
			accepted, checked, mismatches);
		$display("reads hit %0d, out of range %0d, full drops %0d, peak length %0d",
			read_hits, range_hits, full_hits, peak_len);
		if (mismatches == 0)
			$display("indexed_list_store regression: pass");
		else
			$display("indexed_list_store regression: fail");
		$finish;
	end

endmodule
